// ----- sv/keyed_count_table_macros.svh -----
// Assertion macros shared by the keyed count table RTL.
// Each macro expects clk and rst_n to be visible in the including scope.
`ifndef KEYED_COUNT_TABLE_MACROS_SVH
`define KEYED_COUNT_TABLE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define KCT_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that, once seen, must be followed by another on the next edge.
`define KCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kct_pkg.sv -----
// Types and constants for the keyed count table.
// No dependencies; imported by kct_cell and keyed_count_table.
`timescale 1ns / 1ps
`default_nettype none

package kct_pkg;

  localparam int KEY_W      = 16;
  localparam int CNT_W      = 32;
  localparam int POS_W      = 6;
  localparam int USED_OUT_W = 7;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;
  localparam int USER_W     = 2;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // Request travelling down the row of cells, with the answer gathered so far.
  typedef struct packed {
    opcode_t                 op;
    logic [KEY_W-1:0]        key;
    logic signed [CNT_W-1:0] amount;
    logic [POS_W-1:0]        pos;
    logic                    hit;
    logic                    append;
    logic [KEY_W-1:0]        res_key;
    logic signed [CNT_W-1:0] res_count;
  } tok_t;

  // Per-cell occupancy as seen from the fill count.
  typedef struct packed {
    logic valid;  // cell holds an entry
    logic free;   // cell is the next slot to be appended
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- sv/kct_cell.sv -----
// One entry of the keyed count table: stores a key and count and serves
// the request passing through it. Depends on kct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kct_cell
  import kct_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_vld,
  input  tok_t       in_tok,
  input  cell_ctl_t  ctl,
  output logic       out_vld,
  output tok_t       out_tok
);

  // Only cells that a six-bit position can name take part in reads.
  localparam bit POS_REACH = (CELL_INDEX < (1 << POS_W));

  logic [KEY_W-1:0]        key_r, key_nxt;
  logic signed [CNT_W-1:0] count_r, count_nxt;
  logic                    vld_r;
  tok_t                    tok_r, tok_nxt;
  logic signed [CNT_W:0]   sum_w;
  logic signed [CNT_W-1:0] sum_sat;
  logic                    key_match;
  logic                    pos_match;

  // Saturating sum of the stored count and the request amount.
  always_comb begin
    sum_w = {count_r[CNT_W-1], count_r} + {in_tok.amount[CNT_W-1], in_tok.amount};
    if (sum_w[CNT_W] != sum_w[CNT_W-1]) begin
      sum_sat = sum_w[CNT_W] ? CNT_MIN : CNT_MAX;
    end else begin
      sum_sat = sum_w[CNT_W-1:0];
    end
  end

  assign key_match = ctl.valid && (key_r == in_tok.key);
  assign pos_match = POS_REACH && ctl.valid && (in_tok.pos == POS_W'(CELL_INDEX));

  // Serve the request unless an earlier cell has already answered it.
  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    tok_nxt   = in_tok;
    if (in_vld && !in_tok.hit) begin
      case (in_tok.op)
        OP_ADD: begin
          if (key_match) begin
            count_nxt         = sum_sat;
            tok_nxt.hit       = 1'b1;
            tok_nxt.res_key   = key_r;
            tok_nxt.res_count = sum_sat;
          end else if (ctl.free) begin
            key_nxt           = in_tok.key;
            count_nxt         = in_tok.amount;
            tok_nxt.hit       = 1'b1;
            tok_nxt.append    = 1'b1;
            tok_nxt.res_key   = in_tok.key;
            tok_nxt.res_count = in_tok.amount;
          end
        end
        OP_LOOKUP: begin
          if (key_match) begin
            tok_nxt.hit       = 1'b1;
            tok_nxt.res_key   = key_r;
            tok_nxt.res_count = count_r;
          end
        end
        OP_READ: begin
          if (pos_match) begin
            tok_nxt.hit       = 1'b1;
            tok_nxt.res_key   = key_r;
            tok_nxt.res_count = count_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Entry and request payload carry no reset.
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
    tok_r   <= tok_nxt;
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule

`default_nettype wire

// ----- sv/keyed_count_table.sv -----
// Keyed count table: a request walks a row of TABLE_DEPTH cells, one cell per cycle.
// From the last cell the answer goes to the result hold register, then to the output register.
// A new request is taken only once the previous result has moved into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous) empties the table count and the row; the entry
// stores themselves are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_count_table_macros.svh"

module keyed_count_table
  import kct_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [IN_DATA_W-1:0]  in_tdata,   // item_key[15:0], amount[47:16], position[53:48]
  input  wire  [USER_W-1:0]     in_tuser,   // opcode[1:0]
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // found_key[15:0], found_count[47:16],
                                            // entries_used[54:48]
  output logic [USER_W-1:0]     out_tuser   // status[1:0]
);

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  logic                    accept;
  logic                    busy_r;
  logic [UW-1:0]           used_r;
  logic [UW-1:0]           used_nxt;
  tok_t                    head_tok;
  logic [TABLE_DEPTH:0]    chain_vld;
  tok_t                    chain_tok [TABLE_DEPTH+1];
  cell_ctl_t               ctl       [TABLE_DEPTH];
  logic                    tail_vld;
  tok_t                    tail_tok;
  logic                    in_flight;

  status_t                 fin_status;
  logic [KEY_W-1:0]        fin_key;
  logic signed [CNT_W-1:0] fin_count;

  logic                    res_vld_r;
  status_t                 res_status_r;
  logic [KEY_W-1:0]        res_key_r;
  logic signed [CNT_W-1:0] res_count_r;
  logic [USED_OUT_W-1:0]   res_used_r;

  logic                    out_vld_r;
  logic                    out_free;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [USER_W-1:0]       out_user_r;

  // Only one request is in the row at a time.
  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;

  // Unpack the incoming request into the head of the row.
  always_comb begin
    head_tok.op        = opcode_t'(in_tuser);
    head_tok.key       = in_tdata[15:0];
    head_tok.amount    = in_tdata[47:16];
    head_tok.pos       = in_tdata[53:48];
    head_tok.hit       = 1'b0;
    head_tok.append    = 1'b0;
    head_tok.res_key   = '0;
    head_tok.res_count = '0;
  end
  assign chain_tok[0] = head_tok;
  assign chain_vld[0] = accept;

  // The row of cells; each sees whether it holds an entry or is the next free slot.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign ctl[i].valid = (used_r > UW'(i));
    assign ctl[i].free  = (used_r == UW'(i));

    kct_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (chain_vld[i]),
      .in_tok  (chain_tok[i]),
      .ctl     (ctl[i]),
      .out_vld (chain_vld[i+1]),
      .out_tok (chain_tok[i+1])
    );
  end

  assign tail_vld = chain_vld[TABLE_DEPTH];
  assign tail_tok = chain_tok[TABLE_DEPTH];
  assign used_nxt = used_r + UW'(tail_tok.append);

  // Final answer once the request has passed every cell.
  always_comb begin
    fin_status = ST_OK;
    fin_key    = '0;
    fin_count  = '0;
    if (tail_tok.hit) begin
      fin_key   = tail_tok.res_key;
      fin_count = tail_tok.res_count;
    end else begin
      case (tail_tok.op)
        OP_ADD: begin
          fin_status = ST_FULL;
          fin_key    = tail_tok.key;
        end
        OP_LOOKUP: begin
          fin_status = ST_NOT_FOUND;
          fin_key    = tail_tok.key;
        end
        OP_READ: begin
          fin_status = ST_RANGE;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_vld_r || out_tready;

  // Control: busy flag, fill count, result hold stage and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      used_r    <= '0;
      res_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end
      if (tail_vld) begin
        used_r    <= used_nxt;
        res_vld_r <= 1'b1;
      end
      if (res_vld_r && out_free) begin
        res_vld_r <= 1'b0;
        busy_r    <= 1'b0;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (tail_vld) begin
      res_status_r <= fin_status;
      res_key_r    <= fin_key;
      res_count_r  <= fin_count;
      res_used_r   <= USED_OUT_W'(used_nxt);
    end
    if (res_vld_r && out_free) begin
      out_data_r <= {1'b0, res_used_r, res_count_r, res_key_r};
      out_user_r <= res_status_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A request is somewhere past the head of the row or waiting for the output register.
  assign in_flight = res_vld_r || (|chain_vld[TABLE_DEPTH:1]);

  // Checks on the request walk, the fill count and the ready flag.
  `KCT_ASSERT_ALWAYS(a_one_request, $countones(chain_vld) <= 1, "more than one request in row")
  `KCT_ASSERT_ALWAYS(a_used_bound, used_r <= UW'(TABLE_DEPTH), "fill count beyond table depth")
  `KCT_ASSERT_NEXT(a_used_hold, tail_vld && !tail_tok.append, $stable(used_r), "fill count moved")
  `KCT_ASSERT_ALWAYS(a_ready_idle, !in_tready || !in_flight, "ready while a request is in flight")

endmodule

`default_nettype wire

// ----- sim/tb_keyed_count_table.sv -----
// Self-checking testbench for keyed_count_table: adds, lookups, positional reads and no-ops
// are sent as stream requests and each answer is checked against a behavioural table model.
// Depends on kct_pkg and the keyed_count_table RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_keyed_count_table;
  import kct_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int KEY_POOL     = 80;

  // One request as sent, with the idling phase it belongs to.
  typedef struct {
    opcode_t                 op;
    logic [KEY_W-1:0]        key;
    logic signed [CNT_W-1:0] amount;
    logic [POS_W-1:0]        pos;
    int                      phase;
    bit                      drain_first;  // hold back until every answer is in
  } request_t;

  typedef struct {
    status_t                 status;
    logic [KEY_W-1:0]        key;
    logic signed [CNT_W-1:0] count;
    logic [USED_OUT_W-1:0]   used;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  wire                   in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [USER_W-1:0]     in_tuser = '0;
  wire                   out_tvalid;
  logic                  out_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] out_tdata;
  wire  [USER_W-1:0]     out_tuser;

  request_t pending_q[$];
  answer_t  answer_q[$];
  request_t req_on_bus;
  int       phase_now = 0;
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  int       send_idle_pct[3] = '{24, 83, 0};
  int       recv_idle_pct[3] = '{83, 24, 0};

  // Mirror of the table contents.
  logic [KEY_W-1:0]        tbl_key[TABLE_DEPTH];
  logic signed [CNT_W-1:0] tbl_cnt[TABLE_DEPTH];
  int                      tbl_fill = 0;
  logic [KEY_W-1:0]        key_pool[KEY_POOL];

  keyed_count_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one request to the mirror table and works out the answer it must produce.
  task automatic apply_request(input request_t r, output answer_t a);
    int     hit;
    longint sum;
    hit = -1;
    a.status = ST_OK;
    a.key = '0;
    a.count = '0;
    for (int i = 0; i < tbl_fill; i++) begin
      if (hit < 0 && tbl_key[i] == r.key) hit = i;
    end
    case (r.op)
      OP_ADD: begin
        a.key = r.key;
        if (hit >= 0) begin
          sum = longint'(tbl_cnt[hit]) + longint'(r.amount);
          if (sum > longint'(CNT_MAX)) sum = longint'(CNT_MAX);
          else if (sum < longint'(CNT_MIN)) sum = longint'(CNT_MIN);
          tbl_cnt[hit] = sum[CNT_W-1:0];
          a.count = tbl_cnt[hit];
        end else if (tbl_fill < TABLE_DEPTH) begin
          tbl_key[tbl_fill] = r.key;
          tbl_cnt[tbl_fill] = r.amount;
          tbl_fill++;
          a.count = r.amount;
        end else begin
          a.status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) begin
          a.key = tbl_key[hit];
          a.count = tbl_cnt[hit];
        end else begin
          a.status = ST_NOT_FOUND;
          a.key = r.key;
        end
      end
      OP_READ: begin
        if (int'(r.pos) < tbl_fill) begin
          a.key = tbl_key[r.pos];
          a.count = tbl_cnt[r.pos];
        end else begin
          a.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    a.used = tbl_fill[USED_OUT_W-1:0];
  endtask

  task automatic queue_request(input opcode_t op, input logic [KEY_W-1:0] key,
                               input logic signed [CNT_W-1:0] amount,
                               input logic [POS_W-1:0] pos, input int phase,
                               input bit drain_first);
    request_t r;
    r.op = op;
    r.key = key;
    r.amount = amount;
    r.pos = pos;
    r.phase = phase;
    r.drain_first = drain_first;
    pending_q = {pending_q, r};
  endtask

  // Mix of limits, full-width values and small signed steps, so saturation is reached often.
  function automatic logic signed [CNT_W-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0:       return CNT_MAX;
      1:       return CNT_MIN;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                             input logic [CNT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // Request driver: records the accepted request in the model, then offers the next one.
  always @(posedge clk) begin : drive_proc
    answer_t  a;
    request_t nxt;
    bit       taken;
    bit       go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      taken = in_tvalid && in_tready;
      if (taken) begin
        apply_request(req_on_bus, a);
        answer_q = {answer_q, a};
      end
      if (!in_tvalid || taken) begin
        go = 1'b0;
        if (pending_q.size() > 0) begin
          nxt = pending_q[0];
          if (nxt.drain_first) go = (answer_q.size() == 0);
          else go = ($urandom_range(0, 99) >= send_idle_pct[nxt.phase]);
        end
        if (go) begin
          void'(pending_q.pop_front());
          req_on_bus <= nxt;
          in_tdata   <= {2'b00, nxt.pos, nxt.amount, nxt.key};
          in_tuser   <= nxt.op;
          phase_now  <= nxt.phase;
        end
        in_tvalid <= go;
      end
    end
  end

  // Answer monitor: each accepted answer is compared with the oldest outstanding one.
  always @(posedge clk) begin : monitor_proc
    answer_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected answer, expected none, actual status %h data %h",
                   $realtime, out_tuser, out_tdata);
          err_cnt++;
        end else begin
          e = answer_q.pop_front();
          check_field("status", CNT_W'(e.status), CNT_W'(out_tuser));
          check_field("found_key", CNT_W'(e.key), CNT_W'(out_tdata[15:0]));
          check_field("found_count", e.count, out_tdata[47:16]);
          check_field("entries_used", CNT_W'(e.used), CNT_W'(out_tdata[54:48]));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct[phase_now]);
    end
  end

  // Watchdog on the overall run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_keyed_count_table: FAIL");
      $finish;
    end
  end

  initial begin : stim_proc
    int      n;
    int      phase;
    int      r;
    opcode_t op;
    logic [KEY_W-1:0] key;

    // Pool keys are distinct by construction: the low bits hold the pool index.
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = {9'($urandom_range(0, 511)), 7'(i)};
    end

    // Directed part: empty table, limits of every field, saturation both ways, no-op.
    queue_request(OP_READ,   16'h0000, 32'sd0, 6'd0,  0, 1'b0);
    queue_request(OP_LOOKUP, 16'h0000, 32'sd0, 6'd0,  0, 1'b0);
    queue_request(OP_NONE,   16'hFFFF, -32'sd1, 6'd63, 0, 1'b0);
    queue_request(OP_ADD,    16'h0000, CNT_MAX, 6'd0,  0, 1'b0);
    queue_request(OP_ADD,    16'h0000, 32'sd1, 6'd63, 0, 1'b0);
    queue_request(OP_ADD,    16'hFFFF, CNT_MIN, 6'd0,  0, 1'b0);
    queue_request(OP_ADD,    16'hFFFF, -32'sd1, 6'd0,  0, 1'b0);
    queue_request(OP_LOOKUP, 16'hFFFF, 32'sd0, 6'd0,  0, 1'b0);
    queue_request(OP_LOOKUP, 16'h0000, 32'sd0, 6'd0,  0, 1'b0);
    queue_request(OP_LOOKUP, 16'h1234, 32'sd0, 6'd0,  0, 1'b0);
    queue_request(OP_READ,   16'h0000, 32'sd0, 6'd1,  0, 1'b0);
    queue_request(OP_READ,   16'h0000, 32'sd0, 6'd2,  0, 1'b0);
    queue_request(OP_READ,   16'hFFFF, CNT_MAX, 6'd63, 0, 1'b0);
    queue_request(OP_ADD,    16'h0000, CNT_MIN, 6'd0,  0, 1'b0);
    queue_request(OP_ADD,    16'h8001, 32'sd0, 6'd0,  0, 1'b0);
    queue_request(OP_READ,   16'h0000, 32'sd0, 6'd2,  0, 1'b0);
    queue_request(OP_NONE,   16'h0000, 32'sd0, 6'd0,  0, 1'b0);

    // Random part: mostly pool keys so entries are hit again; the pool is larger than the
    // table, so it fills up and later new keys are refused.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase = (n < 640) ? 0 : (n < 1280) ? 1 : 2;
      r = $urandom_range(0, 99);
      if (r < 50) op = OP_ADD;
      else if (r < 75) op = OP_LOOKUP;
      else if (r < 95) op = OP_READ;
      else op = OP_NONE;
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                       : KEY_W'($urandom);
      queue_request(op, key, pick_amount(), POS_W'($urandom), phase,
                    (n == 400) || (n == 1500));
      if (op != OP_NONE) n++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() > 0 || in_tvalid || answer_q.size() > 0);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_keyed_count_table: PASS");
    end else begin
      $display("tb_keyed_count_table: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/kct_pkg.sv
sv/kct_cell.sv
sv/keyed_count_table.sv
sim/tb_keyed_count_table.sv
